FILE: rtl/led_cfm_pkg.sv
package led_cfm_pkg;

    // stream widths
    localparam int unsigned IN_W   = 48;
    localparam int unsigned USER_W = 9;
    localparam int unsigned OUT_W  = 24;

    // color mode codes
    localparam logic [7:0] MODE_WHITE = 8'd0;
    localparam logic [7:0] MODE_TEMP  = 8'd1;
    localparam logic [7:0] MODE_HSL   = 8'd2;
    localparam logic [7:0] MODE_GRAY  = 8'd3;

    // levels and percent limits
    localparam logic [7:0] MAX_LEVEL = 8'd255;
    localparam logic [6:0] PCT_MAX   = 7'd100;
    localparam logic [6:0] LIT_HALF  = 7'd50;

    // hue circle points in degrees
    localparam logic [8:0] HUE_FULL       = 9'd360;
    localparam logic [8:0] HUE_SIXTH      = 9'd60;
    localparam logic [8:0] HUE_THIRD      = 9'd120;
    localparam logic [8:0] HUE_HALF       = 9'd180;
    localparam logic [8:0] HUE_TWO_THIRDS = 9'd240;

    // reciprocal multipliers for division by constants
    localparam logic [15:0] HUE_RECIP          = 16'd46603;    // floor(2^24 / 360)
    localparam logic [25:0] PCT_Q16_RECIP      = 26'd42949673; // ceil(2^32 / 100)
    localparam logic [17:0] PCT_255_RECIP      = 18'd167117;   // ceil(2^16 * 2.55)
    localparam logic [14:0] DIV15_RECIP_WIDE   = 15'd17477;    // ceil(2^18 / 15)
    localparam logic [10:0] DIV15_RECIP_NARROW = 11'd1093;     // ceil(2^14 / 15)

    // rounding bias of the temperature blend
    localparam logic signed [18:0] TEMP_ROUND = 19'sd128;

    // temperature stops, index 0 red, 1 green, 2 blue
    localparam logic [2:0][7:0] STOP_WARM = {8'd68,  8'd158, 8'd255};
    localparam logic [2:0][7:0] STOP_NEUT = {8'd255, 8'd255, 8'd255};
    localparam logic [2:0][7:0] STOP_COOL = {8'd255, 8'd201, 8'd163};

    typedef enum logic [3:0] {
        S_IDLE,
        S_HUE,
        S_MOD,
        S_PQD,
        S_DQ,
        S_DR,
        S_LANE_A,
        S_LANE_B,
        S_FINISH
    } t_state;

    // part of the hue circle a channel position falls in
    typedef enum logic [1:0] {
        SEG_RISE,
        SEG_HIGH,
        SEG_FALL,
        SEG_LOW
    } t_seg;

    typedef struct packed {
        logic cap_in;
        logic en_hue;
        logic en_mod;
        logic en_pqd;
        logic en_dq;
        logic en_dr;
        logic en_lane_a;
        logic en_lane_b;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic in_hsl;
    } t_dp_sts;

    // x / 255 for x below 65280
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] s;
        s = {1'b0, x} + 17'd1 + {9'd0, x[15:8]};
        return s[15:8];
    endfunction

endpackage

FILE: rtl/led_cfm_ctrl.sv
module led_cfm_ctrl import led_cfm_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_s_tvalid,
    output logic    o_s_tready,
    output logic    o_m_tvalid,
    input  logic    i_m_tready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    // state and output valid registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // next state and datapath commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_s_tready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.cap_in = 1'b1;
                    n_state      = i_sts.in_hsl ? S_HUE : S_FINISH;
                end
            end
            S_HUE: begin
                o_cmd.en_hue = 1'b1;
                n_state      = S_MOD;
            end
            S_MOD: begin
                o_cmd.en_mod = 1'b1;
                n_state      = S_PQD;
            end
            S_PQD: begin
                o_cmd.en_pqd = 1'b1;
                n_state      = S_DQ;
            end
            S_DQ: begin
                o_cmd.en_dq = 1'b1;
                n_state     = S_DR;
            end
            S_DR: begin
                o_cmd.en_dr = 1'b1;
                n_state     = S_LANE_A;
            end
            S_LANE_A: begin
                o_cmd.en_lane_a = 1'b1;
                n_state         = S_LANE_B;
            end
            S_LANE_B: begin
                o_cmd.en_lane_b = 1'b1;
                n_state         = S_FINISH;
            end
            S_FINISH: begin
                // output register free or being drained this cycle
                if (!r_out_valid || i_m_tready) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        n_out_valid = o_cmd.load_out | (r_out_valid & ~i_m_tready);
    end

    assign o_m_tvalid = r_out_valid;

endmodule

FILE: rtl/led_cfm_dp.sv
module led_cfm_dp import led_cfm_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [IN_W-1:0]   i_s_tdata,
    input  logic [USER_W-1:0] i_s_tuser,
    input  t_dp_cmd           i_cmd,
    output t_dp_sts           o_sts,
    output logic [OUT_W-1:0]  o_rgb
);

    // captured item
    logic       r_light;
    logic [7:0] r_mode;
    logic [15:0] r_hue;
    logic [6:0] r_sat, r_lit;
    logic [7:0] r_gray_lvl, r_white;
    logic [6:0] in_sat, in_lit;

    assign in_sat = i_s_tdata[22:16];
    assign in_lit = i_s_tdata[29:23];

    assign o_sts.in_hsl = i_s_tuser[0] && (i_s_tuser[8:1] == MODE_HSL);

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_in) begin
            r_light    <= i_s_tuser[0];
            r_mode     <= i_s_tuser[8:1];
            r_hue      <= i_s_tdata[15:0];
            r_sat      <= (in_sat > PCT_MAX) ? PCT_MAX : in_sat;
            r_lit      <= (in_lit > PCT_MAX) ? PCT_MAX : in_lit;
            r_gray_lvl <= i_s_tdata[37:30];
            r_white    <= i_s_tdata[45:38];
        end
    end

    // hue quotient estimate, q16 saturation and lightness, gray for zero saturation
    logic [31:0] hue_prod;
    logic [32:0] sf_prod, lf_prod;
    logic [24:0] gray_prod;
    logic [7:0]  r_hue_quo, r_hsl_gray;
    logic [16:0] r_sf, r_lf;

    assign hue_prod  = r_hue * HUE_RECIP;
    assign sf_prod   = r_sat * PCT_Q16_RECIP;
    assign lf_prod   = r_lit * PCT_Q16_RECIP;
    assign gray_prod = r_lit * PCT_255_RECIP;

    always_ff @(posedge i_clk) begin
        if (i_cmd.en_hue) begin
            r_hue_quo  <= hue_prod[31:24];
            r_sf       <= sf_prod[32:16];
            r_lf       <= lf_prod[32:16];
            r_hsl_gray <= gray_prod[23:16];
        end
    end

    // hue remainder with one correction step, and the l*s product
    logic [16:0] quo_x360, hue_rem;
    logic [9:0]  rem_lo, h_fix;
    logic [33:0] ls_prod;
    logic [8:0]  r_h;
    logic [16:0] r_ls;

    assign quo_x360 = {1'b0, r_hue_quo, 8'd0} + {3'd0, r_hue_quo, 6'd0}
                    + {4'd0, r_hue_quo, 5'd0} + {6'd0, r_hue_quo, 3'd0};
    assign hue_rem  = {1'b0, r_hue} - quo_x360;
    assign rem_lo   = hue_rem[9:0];
    assign h_fix    = (rem_lo >= {1'b0, HUE_FULL}) ? rem_lo - {1'b0, HUE_FULL} : rem_lo;
    assign ls_prod  = r_lf * r_sf;

    always_ff @(posedge i_clk) begin
        if (i_cmd.en_mod) begin
            r_h  <= h_fix[8:0];
            r_ls <= ls_prod[32:16];
        end
    end

    // q, p, d and the three channel positions on the hue circle
    logic [17:0] q_sum, two_lf, p_val, d_val;
    logic [9:0]  h_third, h_two, pos_red, pos_blue;
    logic [16:0] r_p, r_q, r_d;
    logic [8:0]  r_pos [3];

    assign q_sum    = (r_lit < LIT_HALF) ? {1'b0, r_lf} + {1'b0, r_ls}
                                         : {1'b0, r_lf} + {1'b0, r_sf} - {1'b0, r_ls};
    assign two_lf   = {r_lf, 1'b0};
    assign p_val    = (two_lf >= q_sum) ? two_lf - q_sum : '0;
    assign d_val    = (q_sum >= p_val) ? q_sum - p_val : '0;
    assign h_third  = {1'b0, r_h} + {1'b0, HUE_THIRD};
    assign h_two    = {1'b0, r_h} + {1'b0, HUE_TWO_THIRDS};
    assign pos_red  = (h_third >= {1'b0, HUE_FULL}) ? h_third - {1'b0, HUE_FULL} : h_third;
    assign pos_blue = (h_two >= {1'b0, HUE_FULL}) ? h_two - {1'b0, HUE_FULL} : h_two;

    always_ff @(posedge i_clk) begin
        if (i_cmd.en_pqd) begin
            r_q      <= q_sum[16:0];
            r_p      <= p_val[16:0];
            r_d      <= d_val[16:0];
            r_pos[0] <= pos_red[8:0];
            r_pos[1] <= r_h;
            r_pos[2] <= pos_blue[8:0];
        end
    end

    // d split as 60*dq + dr so the per-channel products stay narrow
    logic [29:0] dq_prod;
    logic [16:0] dq_x60, dr_full;
    logic [10:0] r_dq;
    logic [5:0]  r_dr;

    assign dq_prod = r_d[16:2] * DIV15_RECIP_WIDE;
    assign dq_x60  = {r_dq, 6'd0} - {4'd0, r_dq, 2'd0};
    assign dr_full = r_d - dq_x60;

    always_ff @(posedge i_clk) begin
        if (i_cmd.en_dq) begin
            r_dq <= dq_prod[28:18];
        end
        if (i_cmd.en_dr) begin
            r_dr <= dr_full[5:0];
        end
    end

    // one lane per channel
    logic [16:0] r_m1 [3];
    logic [11:0] r_m2 [3];
    t_seg        r_seg [3];
    logic [7:0]  r_chan [3];

    for (genvar k = 0; k < 3; k++) begin : g_lane
        logic [8:0]  pos, fall;
        t_seg        seg;
        logic [5:0]  w;
        logic [16:0] m1;
        logic [11:0] m2;
        logic [20:0] div_prod;
        logic [5:0]  frac_lo;
        logic [16:0] ramp, v;
        logic [24:0] scaled;
        logic [8:0]  c;

        assign pos  = r_pos[k];
        assign fall = HUE_TWO_THIRDS - pos;

        // segment and distance into the ramp
        always_comb begin
            if (pos < HUE_SIXTH) begin
                seg = SEG_RISE;
                w   = pos[5:0];
            end else if (pos < HUE_HALF) begin
                seg = SEG_HIGH;
                w   = '0;
            end else if (pos < HUE_TWO_THIRDS) begin
                seg = SEG_FALL;
                w   = fall[5:0];
            end else begin
                seg = SEG_LOW;
                w   = '0;
            end
        end

        assign m1 = r_dq * w;
        assign m2 = r_dr * w;

        always_ff @(posedge i_clk) begin
            if (i_cmd.en_lane_a) begin
                r_m1[k]  <= m1;
                r_m2[k]  <= m2;
                r_seg[k] <= seg;
            end
        end

        // ramp value, then scale q16 to 8 bits
        assign div_prod = r_m2[k][11:2] * DIV15_RECIP_NARROW;
        assign frac_lo  = div_prod[19:14];
        assign ramp     = r_p + r_m1[k] + {11'd0, frac_lo};

        always_comb begin
            case (r_seg[k])
                SEG_HIGH: v = r_q;
                SEG_LOW:  v = r_p;
                default:  v = ramp;
            endcase
        end

        assign scaled = {v, 8'd0} - {8'd0, v};
        assign c      = scaled[24:16];

        always_ff @(posedge i_clk) begin
            if (i_cmd.en_lane_b) begin
                r_chan[k] <= (c > {1'b0, MAX_LEVEL}) ? MAX_LEVEL : c[7:0];
            end
        end
    end

    // color temperature blend, one lane per channel
    logic [6:0]     tw_x;
    logic [7:0]     tw_f;
    logic [OUT_W-1:0] temp_rgb;

    assign tw_x = r_white[6:0];
    assign tw_f = (tw_x == 7'h7f) ? MAX_LEVEL : {tw_x, 1'b0};

    for (genvar k = 0; k < 3; k++) begin : g_temp
        logic [7:0]         from_lvl, to_lvl, quo;
        logic signed [9:0]  diff;
        logic signed [18:0] num;
        logic               neg;
        logic [18:0]        mag;
        logic signed [10:0] from_s, quo_s, res;

        assign from_lvl = r_white[7] ? STOP_NEUT[k] : STOP_WARM[k];
        assign to_lvl   = r_white[7] ? STOP_COOL[k] : STOP_NEUT[k];
        assign diff     = $signed({2'b00, to_lvl}) - $signed({2'b00, from_lvl});
        assign num      = diff * $signed({1'b0, tw_f}) + TEMP_ROUND;
        assign neg      = num[18];
        assign mag      = neg ? $unsigned(-num) : $unsigned(num);
        assign quo      = div255(mag[15:0]);
        assign from_s   = $signed({3'b000, from_lvl});
        assign quo_s    = $signed({3'b000, quo});
        assign res      = neg ? from_s - quo_s : from_s + quo_s;

        always_comb begin
            if (res[10]) begin
                temp_rgb[k*8 +: 8] = '0;
            end else if (res[9:8] != 2'b00) begin
                temp_rgb[k*8 +: 8] = MAX_LEVEL;
            end else begin
                temp_rgb[k*8 +: 8] = res[7:0];
            end
        end
    end

    // result select and held color
    logic [OUT_W-1:0] r_held, r_out, hsl_rgb, res_rgb;

    assign hsl_rgb = (r_sat == 7'd0) ? {3{r_hsl_gray}} : {r_chan[2], r_chan[1], r_chan[0]};

    always_comb begin
        if (!r_light) begin
            res_rgb = '0;
        end else begin
            unique case (r_mode)
                MODE_WHITE: res_rgb = {3{MAX_LEVEL}};
                MODE_TEMP:  res_rgb = temp_rgb;
                MODE_HSL:   res_rgb = hsl_rgb;
                MODE_GRAY:  res_rgb = {3{r_gray_lvl}};
                default:    res_rgb = r_held;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= '0;
        end else if (i_cmd.load_out && r_light) begin
            r_held <= res_rgb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out <= res_rgb;
        end
    end

    assign o_rgb = r_out;

endmodule

FILE: rtl/led_color_from_mode_core.sv
// led strip color from one light command
// input channel: i_s_tvalid/o_s_tready, one command per item; tuser carries
// light_on and color_mode, tdata carries hue, saturation, lightness,
// gray_level and white_level. output channel: o_m_tvalid/i_m_tready, one
// rgb item per command.
// a light-off, white, temperature, gray or hold command goes from the idle
// state to the finish state, which loads the output register; an hsl command
// first steps through the hue, mod, pqd, dq, dr, lane_a and lane_b states,
// which follow the chain of dependent multiplies in the hsl datapath (hue
// modulo, l*s product, d/60 split, channel ramp products, q16 to 8 bit
// scaling). one command is worked on at a time, taken only in the idle state.
// the finished result sits in an output register, so the next command is
// accepted while the receiver stalls; a second result then waits in the
// datapath until the output register is taken.
// reset clears the controller and the held color (black); modes other than
// 0 to 3 with light on repeat the held color.
module led_color_from_mode_core import led_cfm_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic [IN_W-1:0]   i_s_tdata,   // hue[15:0] saturation[22:16] lightness[29:23]
                                           // gray_level[37:30] white_level[45:38] zero[47:46]
    input  logic [USER_W-1:0] i_s_tuser,   // light_on[0] color_mode[8:1]
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output logic [OUT_W-1:0]  o_m_tdata    // out_red[7:0] out_green[15:8] out_blue[23:16]
);

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    led_cfm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_sts      (dp_sts),
        .o_cmd      (dp_cmd)
    );

    led_cfm_dp u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tdata (i_s_tdata),
        .i_s_tuser (i_s_tuser),
        .i_cmd     (dp_cmd),
        .o_sts     (dp_sts),
        .o_rgb     (o_m_tdata)
    );

endmodule

FILE: rtl/led_cfm_checker.sv
module led_cfm_checker import led_cfm_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_s_tvalid,
    input logic              o_s_tready,
    input logic [USER_W-1:0] i_s_tuser,
    input logic              o_m_tvalid,
    input logic              i_m_tready,
    input logic [OUT_W-1:0]  o_m_tdata
);

    logic       in_acc, out_acc;
    logic [1:0] r_pend;

    assign in_acc  = i_s_tvalid && o_s_tready;
    assign out_acc = o_m_tvalid && i_m_tready;

    // items accepted but not yet delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else begin
            case ({in_acc, out_acc})
                2'b10:   r_pend <= r_pend + 2'd1;
                2'b01:   r_pend <= r_pend - 2'd1;
                default: r_pend <= r_pend;
            endcase
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("output item changed while stalled");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !o_s_tready)
        else $error("input ready right after an accepted item");

    a_pend_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend != 2'd3) && (!o_m_tvalid || r_pend != 2'd0))
        else $error("result count out of step with accepted items");

    a_black_when_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && !i_s_tuser[0] && !o_m_tvalid
        |=> ##1 (o_m_tvalid && o_m_tdata == '0))
        else $error("light off did not give black");

    a_white_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_s_tuser[0] && (i_s_tuser[8:1] == MODE_WHITE) && !o_m_tvalid
        |=> ##1 (o_m_tvalid && o_m_tdata == {3{MAX_LEVEL}}))
        else $error("white mode did not give full white");

endmodule

bind led_color_from_mode_core led_cfm_checker u_led_cfm_checker (.*);

FILE: tb/led_color_from_mode_core_tb.sv
`timescale 1ns / 100ps

module led_color_from_mode_core_tb;
    import led_cfm_pkg::*;

    // modes outside 0..3 repeat the held color
    localparam logic [7:0] MODE_HOLD_LO = 8'd4;
    localparam logic [7:0] MODE_HOLD_HI = 8'd255;

    localparam int unsigned RANDOM_ITEMS = 1700;
    localparam int unsigned DRAIN_CYCLES = 20;
    localparam int unsigned CYCLE_LIMIT  = 400000;

    // one light command as it travels on the input stream
    typedef struct packed {
        logic        light_on;
        logic [7:0]  mode;
        logic [15:0] hue;
        logic [6:0]  sat;
        logic [6:0]  lit;
        logic [7:0]  gray;
        logic [7:0]  white;
    } t_cmd;

    // rgb item, red in the lowest byte as on o_m_tdata
    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } t_rgb;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_s_tvalid = 1'b0;
    logic              o_s_tready;
    logic [IN_W-1:0]   i_s_tdata = '0;   // hue, saturation, lightness, gray_level,
                                         // white_level, zero pad
    logic [USER_W-1:0] i_s_tuser = '0;   // light_on, color_mode
    logic              o_m_tvalid;
    logic              i_m_tready = 1'b0;
    logic [OUT_W-1:0]  o_m_tdata;        // out_red, out_green, out_blue

    led_color_from_mode_core u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    t_cmd        cmd_q[$];
    t_rgb        rgb_q[$];
    t_rgb        held_rgb = '0;
    logic        in_taken = 1'b0;
    int unsigned cycles = 0;
    int unsigned errors = 0;
    int unsigned rgb_checked = 0;
    int unsigned n_off = 0, n_white = 0, n_temp = 0, n_hsl = 0, n_gray = 0, n_hold = 0;

    // color temperature stops, warm to neutral to cool
    localparam int WARM_R = 255, WARM_G = 158, WARM_B = 68;
    localparam int NEUT_R = 255, NEUT_G = 255, NEUT_B = 255;
    localparam int COOL_R = 163, COOL_G = 201, COOL_B = 255;

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
    end

    // one channel of the temperature blend, signed division toward zero
    function automatic logic [7:0] temp_mix(input int from_v, input int to_v, input int f);
        int v;
        v = from_v + ((to_v - from_v) * f + 128) / 255;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return v[7:0];
    endfunction

    function automatic t_rgb temp_color(input logic [7:0] w);
        t_rgb c;
        int   f;
        if (w <= 8'd127) begin
            f = (int'(w) * 255) / 127;
            c.red   = temp_mix(WARM_R, NEUT_R, f);
            c.green = temp_mix(WARM_G, NEUT_G, f);
            c.blue  = temp_mix(WARM_B, NEUT_B, f);
        end else begin
            f = ((int'(w) - 128) * 255) / 127;
            c.red   = temp_mix(NEUT_R, COOL_R, f);
            c.green = temp_mix(NEUT_G, COOL_G, f);
            c.blue  = temp_mix(NEUT_B, COOL_B, f);
        end
        return c;
    endfunction

    // value of one channel at hue position t, scaled from q16 to 8 bits
    function automatic logic [7:0] hue_ramp(input longint t, input longint p,
                                            input longint q, input longint d);
        longint v;
        longint c;
        if (t < 60) v = p + (d * t) / 60;
        else if (t < 180) v = q;
        else if (t < 240) v = p + (d * (240 - t)) / 60;
        else v = p;
        c = (v * 255) >>> 16;
        if (c > 255) c = 255;
        return c[7:0];
    endfunction

    function automatic t_rgb hsl_color(input logic [15:0] hue, input logic [6:0] sat,
                                       input logic [6:0] lit);
        t_rgb   c;
        longint h, s, l, sf, lf, ls, q, p, d, g;
        h = longint'(hue) % 360;
        s = (sat > 7'd100) ? 100 : longint'(sat);
        l = (lit > 7'd100) ? 100 : longint'(lit);
        if (s == 0) begin
            g = (l * 255) / 100;
            c.red   = g[7:0];
            c.green = g[7:0];
            c.blue  = g[7:0];
        end else begin
            sf = (s * 65536) / 100;
            lf = (l * 65536) / 100;
            ls = (lf * sf) >>> 16;
            q = (l < 50) ? lf + ls : lf + sf - ls;
            p = 2 * lf - q;
            if (p < 0) p = 0;
            d = q - p;
            if (d < 0) d = 0;
            c.red   = hue_ramp((h + 120) % 360, p, q, d);
            c.green = hue_ramp(h, p, q, d);
            c.blue  = hue_ramp((h + 240) % 360, p, q, d);
        end
        return c;
    endfunction

    // expected strip color for one command, updating the held color
    function automatic t_rgb strip_color(input t_cmd c);
        t_rgb res;
        if (!c.light_on) begin
            n_off++;
            return '0;
        end
        res = held_rgb;
        case (c.mode)
            MODE_WHITE: begin
                res = '1;
                n_white++;
            end
            MODE_TEMP: begin
                res = temp_color(c.white);
                n_temp++;
            end
            MODE_HSL: begin
                res = hsl_color(c.hue, c.sat, c.lit);
                n_hsl++;
            end
            MODE_GRAY: begin
                res = '{blue: c.gray, green: c.gray, red: c.gray};
                n_gray++;
            end
            default: begin
                n_hold++;
            end
        endcase
        held_rgb = res;
        return res;
    endfunction

    task automatic add_cmd(input logic on, input logic [7:0] mode, input logic [15:0] hue,
                           input logic [6:0] sat, input logic [6:0] lit,
                           input logic [7:0] gray, input logic [7:0] white);
        cmd_q.push_back('{light_on: on, mode: mode, hue: hue, sat: sat, lit: lit,
                          gray: gray, white: white});
    endtask

    function automatic t_cmd random_cmd();
        t_cmd        c;
        int unsigned sel;
        c.light_on = ($urandom_range(0, 7) != 0);
        sel = $urandom_range(0, 9);
        if (sel == 0) c.mode = MODE_WHITE;
        else if (sel <= 2) c.mode = MODE_TEMP;
        else if (sel <= 6) c.mode = MODE_HSL;
        else if (sel == 7) c.mode = MODE_GRAY;
        else c.mode = 8'($urandom_range(MODE_HOLD_LO, MODE_HOLD_HI));
        // hue mostly within two turns, sometimes over the whole range
        c.hue = ($urandom_range(0, 2) == 0) ? 16'($urandom) : 16'($urandom_range(0, 719));
        sel = $urandom_range(0, 9);
        if (sel == 0) c.sat = '0;
        else if (sel == 1) c.sat = 7'($urandom_range(101, 127));
        else c.sat = 7'($urandom_range(0, 100));
        c.lit = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(101, 127))
                                            : 7'($urandom_range(0, 100));
        c.gray  = 8'($urandom);
        c.white = 8'($urandom);
        return c;
    endfunction

    // sender: bursts of items with random gaps between them
    int unsigned burst_left = 0;
    int unsigned gap_left = 0;
    t_cmd        drv_cmd;

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else if (!i_s_tvalid || in_taken) begin
            if (gap_left > 0) begin
                gap_left--;
                i_s_tvalid <= 1'b0;
            end else if (cmd_q.size() > 0) begin
                drv_cmd = cmd_q.pop_front();
                i_s_tdata  <= {2'b00, drv_cmd.white, drv_cmd.gray, drv_cmd.lit,
                               drv_cmd.sat, drv_cmd.hue};
                i_s_tuser  <= {drv_cmd.mode, drv_cmd.light_on};
                i_s_tvalid <= 1'b1;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 30);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end else begin
                    burst_left--;
                end
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // receiver: alternating ready and stall stretches of random length
    int unsigned rdy_left = 0;
    logic        rdy_level = 1'b1;

    always @(negedge i_clk) begin
        if (rdy_left == 0) begin
            rdy_level = ~rdy_level;
            rdy_left = rdy_level ? $urandom_range(1, 40) : $urandom_range(1, 15);
        end else begin
            rdy_left--;
        end
        i_m_tready <= rdy_level;
    end

    // monitor: predict on input accept, check on output accept
    t_cmd mon_cmd;
    t_rgb mon_got;
    t_rgb mon_want;

    always @(posedge i_clk) begin
        in_taken <= i_rst_n && i_s_tvalid && o_s_tready;
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready) begin
                mon_cmd.light_on = i_s_tuser[0];
                mon_cmd.mode     = i_s_tuser[8:1];
                mon_cmd.hue      = i_s_tdata[15:0];
                mon_cmd.sat      = i_s_tdata[22:16];
                mon_cmd.lit      = i_s_tdata[29:23];
                mon_cmd.gray     = i_s_tdata[37:30];
                mon_cmd.white    = i_s_tdata[45:38];
                rgb_q.push_back(strip_color(mon_cmd));
            end
            if (o_m_tvalid && i_m_tready) begin
                mon_got = o_m_tdata;
                if (rgb_q.size() == 0) begin
                    $error("rgb item with no command pending: %h", mon_got);
                    errors++;
                end else begin
                    mon_want = rgb_q.pop_front();
                    rgb_checked++;
                    if (mon_got.red !== mon_want.red) begin
                        $error("out_red: expected %0d, got %0d", mon_want.red, mon_got.red);
                        errors++;
                    end
                    if (mon_got.green !== mon_want.green) begin
                        $error("out_green: expected %0d, got %0d",
                               mon_want.green, mon_got.green);
                        errors++;
                    end
                    if (mon_got.blue !== mon_want.blue) begin
                        $error("out_blue: expected %0d, got %0d",
                               mon_want.blue, mon_got.blue);
                        errors++;
                    end
                end
            end
        end
    end

    // stimulus and end of run
    initial begin
        // hold after reset repeats black, then white is held across light off
        add_cmd(1'b1, MODE_HOLD_HI, 16'hffff, 7'h7f, 7'h7f, 8'hff, 8'hff);
        add_cmd(1'b1, MODE_WHITE, 16'd0, 7'd0, 7'd0, 8'd0, 8'd0);
        add_cmd(1'b0, MODE_WHITE, 16'hffff, 7'h7f, 7'h7f, 8'hff, 8'hff);
        add_cmd(1'b1, MODE_HOLD_LO, 16'd0, 7'd0, 7'd0, 8'd0, 8'd0);
        add_cmd(1'b0, MODE_HSL, 16'd90, 7'd50, 7'd50, 8'd7, 8'd7);
        // temperature ends and the segment boundary
        add_cmd(1'b1, MODE_TEMP, 16'd0, 7'd0, 7'd0, 8'd0, 8'd0);
        add_cmd(1'b1, MODE_TEMP, 16'd0, 7'd0, 7'd0, 8'd0, 8'd64);
        add_cmd(1'b1, MODE_TEMP, 16'd0, 7'd0, 7'd0, 8'd0, 8'd127);
        add_cmd(1'b1, MODE_TEMP, 16'd0, 7'd0, 7'd0, 8'd0, 8'd128);
        add_cmd(1'b1, MODE_TEMP, 16'd0, 7'd0, 7'd0, 8'd0, 8'd255);
        add_cmd(1'b1, MODE_HOLD_HI, 16'd0, 7'd0, 7'd0, 8'd0, 8'd0);
        // hsl: gray path, saturation and lightness over 100, hue wrap
        add_cmd(1'b1, MODE_HSL, 16'd0, 7'd0, 7'd100, 8'd0, 8'd0);
        add_cmd(1'b1, MODE_HSL, 16'd17, 7'd0, 7'd127, 8'd0, 8'd0);
        add_cmd(1'b1, MODE_HSL, 16'd0, 7'd100, 7'd50, 8'd0, 8'd0);
        add_cmd(1'b1, MODE_HSL, 16'd359, 7'd127, 7'd127, 8'd0, 8'd0);
        add_cmd(1'b1, MODE_HSL, 16'd360, 7'd100, 7'd49, 8'd0, 8'd0);
        add_cmd(1'b1, MODE_HSL, 16'hffff, 7'd1, 7'd1, 8'd0, 8'd0);
        add_cmd(1'b1, MODE_HSL, 16'd60, 7'd80, 7'd50, 8'd0, 8'd0);
        add_cmd(1'b1, MODE_HSL, 16'd180, 7'd33, 7'd70, 8'd0, 8'd0);
        add_cmd(1'b1, MODE_HSL, 16'd240, 7'd127, 7'd0, 8'd0, 8'd0);
        add_cmd(1'b1, MODE_HOLD_LO, 16'd0, 7'd0, 7'd0, 8'd0, 8'd0);
        // gray extremes
        add_cmd(1'b1, MODE_GRAY, 16'd0, 7'd0, 7'd0, 8'd0, 8'd0);
        add_cmd(1'b1, MODE_GRAY, 16'd0, 7'd0, 7'd0, 8'd255, 8'd0);
        add_cmd(1'b1, MODE_HOLD_HI, 16'd0, 7'd0, 7'd0, 8'd0, 8'd0);
        repeat (RANDOM_ITEMS) cmd_q.push_back(random_cmd());

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        while ((cmd_q.size() != 0 || i_s_tvalid || rgb_q.size() != 0)
               && cycles < CYCLE_LIMIT)
            @(posedge i_clk);
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d rgb items outstanding",
                     cycles, rgb_q.size());
            $display("led_color_from_mode_core_tb: FAIL");
        end else begin
            repeat (DRAIN_CYCLES) @(posedge i_clk);
            $display("commands: %0d off, %0d white, %0d temperature, %0d hsl, %0d gray, %0d hold",
                     n_off, n_white, n_temp, n_hsl, n_gray, n_hold);
            $display("rgb items checked: %0d, mismatches: %0d, leftover: %0d",
                     rgb_checked, errors, rgb_q.size());
            if (errors == 0 && rgb_q.size() == 0) begin
                $display("led_color_from_mode_core_tb: PASS");
            end else begin
                $display("led_color_from_mode_core_tb: FAIL");
            end
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/led_cfm_pkg.sv
rtl/led_cfm_ctrl.sv
rtl/led_cfm_dp.sv
rtl/led_color_from_mode_core.sv
rtl/led_cfm_checker.sv
tb/led_color_from_mode_core_tb.sv
